// ===== hdl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for the PWM prescaler/TOP search
// Prescaler table, waveform mode codes, register indexes and queue entry.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int CLK_W      = 25;
  localparam int WANT_W     = 16;
  localparam int TOP_W      = 16;
  localparam int ACH_W      = 18;
  localparam int DVS_W      = 19;
  localparam int TABLE_LEN  = 7;
  localparam int NUM_PRESCALERS_DEF = 7;
  localparam int QDEPTH     = 2;

  localparam logic [CLK_W-1:0] CPU_CLOCK_RST = 25'd16000000;
  localparam logic [TOP_W-1:0] MAXTOP_8      = 16'h00FF;
  localparam logic [TOP_W-1:0] MAXTOP_16     = 16'hFFFF;
  // 255 << 11, divisor of the start value on the 8-bit timer
  localparam logic [DVS_W-1:0] START_DVS_8   = 19'd522240;

  localparam logic [2:0] MODE_DEFAULT  = 3'd0;
  localparam logic [2:0] MODE_FAST_VAR = 3'd1;
  localparam logic [2:0] MODE_PC_VAR   = 3'd2;
  localparam logic [2:0] MODE_FAST_FIX = 3'd3;
  localparam logic [2:0] MODE_PC_FIX   = 3'd4;

  localparam logic [2:0] CODE_STOPPED  = 3'd0;

  localparam logic CFG_CPU_CLOCK = 1'b0;
  localparam logic CFG_CMP_TOP   = 1'b1;

  typedef enum logic [1:0] {
    K_UNUSABLE = 2'd0,
    K_DEFAULT  = 2'd1,
    K_SEARCH   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [WANT_W-1:0] want;
    logic              is8;
    logic              fixed;
  } entry_t;

  // log2 of the prescaler at table position i
  function automatic logic [3:0] pre_shift(input logic [2:0] i);
    logic [3:0] s;
    unique case (i)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd3;
      3'd2:    s = 4'd5;
      3'd3:    s = 4'd6;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd8;
      3'd6:    s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/pps_div.sv =====
// ----------------------------------------------------------------------------
// pps_div: iterative restoring divider
// One quotient bit per cycle; done pulses as the last bit is registered.
// ----------------------------------------------------------------------------
module pps_div
  import pps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CLK_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [CLK_W-1:0] quotient
);

  localparam int CNT_W = $clog2(CLK_W);

  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_r, rem_nxt, trial;
  logic [CLK_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic             ge;

  assign trial = {rem_r[DVS_W-1:0], quo_r[CLK_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt = ge ? trial - {1'b0, dvs_r} : trial;
    quo_nxt = {quo_r[CLK_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(CLK_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/pps_front.sv =====
// ----------------------------------------------------------------------------
// pps_front: request intake and classification
// Registers each request and sorts it into unusable, default or search.
// ----------------------------------------------------------------------------
module pps_front
  import pps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WANT_W-1:0] in_desired_hz,
  input  logic              in_timer_is_8bit,
  input  logic              in_timer_usable,
  input  logic              cmp_top,
  output logic              push_valid,
  input  logic              push_ready,
  output entry_t            push_entry
);

  logic   v_r;
  entry_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt.want  = in_desired_hz;
    ent_nxt.is8   = in_timer_is_8bit;
    ent_nxt.fixed = in_timer_is_8bit && !cmp_top;
    if (!in_timer_usable)          ent_nxt.kind = K_UNUSABLE;
    else if (in_desired_hz == '0)  ent_nxt.kind = K_DEFAULT;
    else                           ent_nxt.kind = K_SEARCH;
  end

  assign in_ready = !v_r || push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ent_r <= ent_nxt;
    end
  end

  assign push_valid = v_r;
  assign push_entry = ent_r;

endmodule

// ===== hdl/pps_queue.sv =====
// ----------------------------------------------------------------------------
// pps_queue: short FIFO between intake and search sequencer
// ----------------------------------------------------------------------------
module pps_queue
  import pps_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop,
  output entry_t pop_entry
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  entry_t           mem_r [QDEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = mem_r[rp_r];

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= inc(wp_r);
      if (do_pop)  rp_r <= inc(rp_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_entry;
  end

endmodule

// ===== hdl/pps_back.sv =====
// ----------------------------------------------------------------------------
// pps_back: prescaler search sequencer
// Walks the prescaler table with two shared dividers, keeps the best setting
// and loads the result register.
// ----------------------------------------------------------------------------
module pps_back
  import pps_pkg::*;
#(
  parameter int NUM_PRESCALERS = NUM_PRESCALERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CLK_W-1:0]  cpu_clock,
  input  logic              q_valid,
  output logic              q_pop,
  input  entry_t            q_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_applied,
  output logic [2:0]        out_wave_mode,
  output logic [2:0]        out_prescaler_code,
  output logic [TOP_W-1:0]  out_top_value,
  output logic [ACH_W-1:0]  out_achieved_hz
);

  localparam int LIM = (NUM_PRESCALERS < TABLE_LEN) ? NUM_PRESCALERS : TABLE_LEN;
  localparam logic [2:0] LIM_I = 3'(LIM);

  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001,
    S_NEXT = 7'b000_0010,
    S_QDIV = 7'b000_0100,
    S_TOPS = 7'b000_1000,
    S_FDIV = 7'b001_0000,
    S_UPD  = 7'b010_0000,
    S_DONE = 7'b100_0000
  } state_t;

  state_t            st_r, st_nxt;
  entry_t            ent_r;
  logic [2:0]        i_r, rank_r;
  logic [CLK_W-1:0]  best_r;
  logic [TOP_W-1:0]  rf_r, rp_r, top_r;
  logic [2:0]        mode_r, code_r;
  logic [CLK_W-1:0]  ach_r;
  logic              appl_r;
  logic              ov_r;

  logic              start_a, start_b, done_a, done_b;
  logic [CLK_W-1:0]  dvd_a, dvd_b, quo_a, quo_b;
  logic [DVS_W-1:0]  dvs_a, dvs_b;

  logic [TOP_W-1:0]  maxtop;
  logic [3:0]        sh;
  logic [CLK_W-1:0]  clk_sh, clk_sh1;
  logic              skip;
  logic [CLK_W-1:0]  rf_full, rp_full;
  logic [TOP_W-1:0]  rf_c, rp_c;
  logic [CLK_W-1:0]  want_w, db, dff, dpc;
  logic              take_f, take_p;
  logic              out_free;
  logic [13:0]       st_x;
  logic [14:0]       st_sum;
  logic [CLK_W-1:0]  best0;

  function automatic logic [CLK_W-1:0] absd(input logic [CLK_W-1:0] a,
                                            input logic [CLK_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [TOP_W-1:0] clampt(input logic [CLK_W-1:0] v,
                                              input logic [TOP_W-1:0] hi);
    logic [TOP_W-1:0] r;
    if (v == '0)                          r = TOP_W'(1);
    else if (v > {{(CLK_W-TOP_W){1'b0}}, hi}) r = hi;
    else                                  r = v[TOP_W-1:0];
    return r;
  endfunction

  // start value: cpu_clock / (255 << 11) + 1 on the 8-bit timer, else 1.
  // x / 255 as (x + (x >> 8) + 1) >> 8, exact for x below 2^16 - 1, which covers the 14-bit x here.
  assign st_x   = cpu_clock[CLK_W-1:11];
  assign st_sum = {1'b0, st_x} + {9'b0, st_x[13:8]} + 15'd1;
  assign best0  = q_entry.is8 ? CLK_W'(st_sum[14:8]) + 1'b1 : CLK_W'(1);

  assign maxtop  = ent_r.is8 ? MAXTOP_8 : MAXTOP_16;
  assign sh      = pre_shift(i_r);
  assign clk_sh  = cpu_clock >> sh;
  assign clk_sh1 = cpu_clock >> (sh + 4'd1);
  assign skip    = !ent_r.is8 && (i_r == 3'd2 || i_r == 3'd4);

  assign rf_full = (quo_a == '0) ? '0 : quo_a - 1'b1;
  assign rp_full = quo_a >> 1;
  assign rf_c    = clampt(rf_full, maxtop);
  assign rp_c    = clampt(rp_full, maxtop);

  assign want_w  = {{(CLK_W-WANT_W){1'b0}}, ent_r.want};
  assign db      = absd(best_r, want_w);
  assign dff     = absd(quo_a, want_w);
  assign dpc     = absd(quo_b, want_w);
  assign take_f  = (dff < db) && (dff <= dpc);
  assign take_p  = !take_f && (dpc < db);

  assign out_free = !ov_r || out_ready;
  assign q_pop    = (st_r == S_IDLE) && q_valid;

  // divider operand selection
  always_comb begin
    start_a = 1'b0;
    start_b = 1'b0;
    dvd_a   = clk_sh;
    dvs_a   = DVS_W'(ent_r.want);
    dvd_b   = clk_sh1;
    dvs_b   = DVS_W'(rp_r);
    unique case (st_r)
      S_NEXT: start_a = (i_r != LIM_I) && !skip && !ent_r.fixed;
      S_TOPS: begin
        dvs_a   = DVS_W'({1'b0, rf_r} + 17'd1);
        start_a = 1'b1;
        start_b = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        if (q_entry.kind != K_SEARCH) st_nxt = S_DONE;
        else                         st_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (i_r == LIM_I)       st_nxt = S_DONE;
        else if (skip)          st_nxt = S_NEXT;
        else if (ent_r.fixed)   st_nxt = S_TOPS;
        else                    st_nxt = S_QDIV;
      end
      S_QDIV: if (done_a) st_nxt = S_TOPS;
      S_TOPS: st_nxt = S_FDIV;
      S_FDIV: if (done_a && done_b) st_nxt = S_UPD;
      S_UPD:  st_nxt = S_NEXT;
      S_DONE: if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DONE && out_free) ov_r <= 1'b1;
      else if (out_ready)             ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        ent_r  <= q_entry;
        i_r    <= '0;
        rank_r <= '0;
        best_r <= best0;
        mode_r <= MODE_DEFAULT;
        code_r <= CODE_STOPPED;
        top_r  <= MAXTOP_8;
        ach_r  <= '0;
        appl_r <= q_entry.kind != K_UNUSABLE;
      end
      S_NEXT: begin
        if (i_r != LIM_I) begin
          if (skip) begin
            i_r <= i_r + 1'b1;
          end else begin
            rank_r <= rank_r + 1'b1;
            rf_r   <= maxtop;
            rp_r   <= maxtop;
          end
        end
      end
      S_QDIV: if (done_a) begin
        rf_r <= rf_c;
        rp_r <= rp_c;
      end
      S_UPD: begin
        if (take_f) begin
          mode_r <= ent_r.fixed ? MODE_FAST_FIX : MODE_FAST_VAR;
          best_r <= quo_a;
          ach_r  <= quo_a;
          top_r  <= rf_r;
          code_r <= ent_r.is8 ? i_r + 1'b1 : rank_r;
        end else if (take_p) begin
          mode_r <= ent_r.fixed ? MODE_PC_FIX : MODE_PC_VAR;
          best_r <= quo_b;
          ach_r  <= quo_b;
          top_r  <= rp_r;
          code_r <= ent_r.is8 ? i_r + 1'b1 : rank_r;
        end
        i_r <= i_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_DONE && out_free) begin
      out_applied        <= appl_r;
      out_wave_mode      <= mode_r;
      out_prescaler_code <= code_r;
      out_top_value      <= top_r;
      out_achieved_hz    <= ach_r[ACH_W-1:0];
    end
  end

  assign out_valid = ov_r;

  pps_div u_div_a (
    .clk(clk), .rst_n(rst_n), .start(start_a), .dividend(dvd_a),
    .divisor(dvs_a), .done(done_a), .quotient(quo_a)
  );

  pps_div u_div_b (
    .clk(clk), .rst_n(rst_n), .start(start_b), .dividend(dvd_b),
    .divisor(dvs_b), .done(done_b), .quotient(quo_b)
  );

endmodule

// ===== hdl/pwm_prescaler_top_search_unit.sv =====
// ----------------------------------------------------------------------------
// pwm_prescaler_top_search_unit: PWM prescaler and TOP search
// Picks waveform mode, clock-select code and TOP for a requested frequency.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one transaction per request, carrying
//    desired frequency, timer kind and usability.
//  - Output channel (out_valid/out_ready): one transaction per request, in
//    request order: applied, wave mode, prescaler code, TOP, achieved Hz.
//  - Config port (cfg_we/cfg_index/cfg_data): index 0 cpu clock in Hz,
//    index 1 compare-as-TOP for the 8-bit timer. Write only while idle.
//  - Sequencing: unusable or zero-frequency requests skip the search and go
//    straight to the result register. A search runs on two shared 25-step
//    dividers: per used prescaler, a TOP quotient (skipped on fixed TOP),
//    then both frequencies at once, then bookkeeping. The sequencer takes
//    the next request only after the last result is loaded.
//  - Intake and search are split by a two-entry queue, so up to three
//    requests are taken while a search runs or a result waits.
//  - Reset (rst_n low, synchronous): queue and sequencer empty, cpu clock
//    16000000, compare-as-TOP off.
//  - A stalled receiver holds the result register; the sequencer then waits
//    and the queue fills, after which in_ready drops.
// ----------------------------------------------------------------------------
module pwm_prescaler_top_search_unit
  import pps_pkg::*;
#(
  parameter int NUM_PRESCALERS = NUM_PRESCALERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WANT_W-1:0] in_desired_hz,
  input  logic              in_timer_is_8bit,
  input  logic              in_timer_usable,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_applied,
  output logic [2:0]        out_wave_mode,
  output logic [2:0]        out_prescaler_code,
  output logic [TOP_W-1:0]  out_top_value,
  output logic [ACH_W-1:0]  out_achieved_hz,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CLK_W-1:0]  cfg_data
);

  // configuration registers
  logic [CLK_W-1:0] cpu_clock_r;
  logic             cmp_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_clock_r <= CPU_CLOCK_RST;
      cmp_top_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CPU_CLOCK: cpu_clock_r <= cfg_data;
        CFG_CMP_TOP:   cmp_top_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // intake -> queue
  logic   f_valid, f_ready;
  entry_t f_entry;

  pps_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_desired_hz(in_desired_hz), .in_timer_is_8bit(in_timer_is_8bit),
    .in_timer_usable(in_timer_usable), .cmp_top(cmp_top_r),
    .push_valid(f_valid), .push_ready(f_ready), .push_entry(f_entry)
  );

  // queue -> search sequencer
  logic   q_valid, q_pop;
  entry_t q_entry;

  pps_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_entry(f_entry),
    .pop_valid(q_valid), .pop(q_pop), .pop_entry(q_entry)
  );

  pps_back #(.NUM_PRESCALERS(NUM_PRESCALERS)) u_back (
    .clk(clk), .rst_n(rst_n), .cpu_clock(cpu_clock_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_entry(q_entry),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_applied(out_applied), .out_wave_mode(out_wave_mode),
    .out_prescaler_code(out_prescaler_code), .out_top_value(out_top_value),
    .out_achieved_hz(out_achieved_hz)
  );

endmodule

// ===== verif/pwm_prescaler_top_search_unit_tb.sv =====
// ----------------------------------------------------------------------------
// pwm_prescaler_top_search_unit_tb: self-checking bench for the TOP search
// Drives requests and config writes, predicts each result in a scoreboard
// class and compares every result transaction field by field, in order.
// ----------------------------------------------------------------------------
module pwm_prescaler_top_search_unit_tb
  import pps_pkg::*;
();

  typedef struct {
    logic              applied;
    logic [2:0]        mode;
    logic [2:0]        code;
    logic [TOP_W-1:0]  top;
    logic [ACH_W-1:0]  ach;
  } search_res_t;

  // Scoreboard: holds its own copy of the registers and the expected queue.
  class search_scoreboard;
    logic [CLK_W-1:0] cpu_hz;
    logic             cmp_top;
    search_res_t      pending[$];
    int               errors;

    function void init();
      cpu_hz  = CPU_CLOCK_RST;
      cmp_top = 1'b0;
      errors  = 0;
    endfunction

    function void set_reg(logic idx, logic [CLK_W-1:0] val);
      if (idx == CFG_CPU_CLOCK) cpu_hz = val;
      else cmp_top = val[0];
    endfunction

    // Walks the prescaler list exactly as the block is meant to.
    function void note_request(logic [WANT_W-1:0] want, logic is8, logic usable);
      longint unsigned pres[7];
      longint unsigned clk, maxtop, best, p, q, rf, rp, ff, fp, db, dff, dpc;
      search_res_t r;
      int rank;
      logic fixed;
      pres = '{1, 8, 32, 64, 128, 256, 1024};
      clk = cpu_hz;
      fixed = is8 && !cmp_top;
      maxtop = is8 ? 255 : 65535;
      r.applied = usable; r.mode = MODE_DEFAULT; r.code = CODE_STOPPED;
      r.top = MAXTOP_8; r.ach = '0;
      rank = 0;
      if (usable && want != 0) begin
        best = clk / (maxtop << 11) + 1;
        for (int i = 0; i < 7; i++) begin
          p = pres[i];
          if (!is8 && (p == 32 || p == 128)) continue;
          rank++;
          if (fixed) begin
            rf = maxtop; rp = maxtop;
          end else begin
            q = clk / (p * want);
            rf = (q > 0) ? q - 1 : 0;
            rp = q / 2;
          end
          if (rf < 1) rf = 1; else if (rf > maxtop) rf = maxtop;
          if (rp < 1) rp = 1; else if (rp > maxtop) rp = maxtop;
          ff = clk / (p * (1 + rf));
          fp = clk / (2 * p * rp);
          db  = (best > want) ? best - want : want - best;
          dff = (ff > want) ? ff - want : want - ff;
          dpc = (fp > want) ? fp - want : want - fp;
          if (dff < db && dff <= dpc) begin
            r.mode = fixed ? MODE_FAST_FIX : MODE_FAST_VAR;
            best = ff; r.top = TOP_W'(rf); r.ach = ACH_W'(ff);
            r.code = is8 ? 3'(i + 1) : 3'(rank);
          end else if (dpc < db) begin
            r.mode = fixed ? MODE_PC_FIX : MODE_PC_VAR;
            best = fp; r.top = TOP_W'(rp); r.ach = ACH_W'(fp);
            r.code = is8 ? 3'(i + 1) : 3'(rank);
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(search_res_t act);
      search_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transaction", $realtime);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (act.applied !== e.applied) begin
        $display("%0t: applied exp %0d got %0d", $realtime, e.applied, act.applied);
        errors++;
      end
      if (act.mode !== e.mode) begin
        $display("%0t: wave_mode exp %0d got %0d", $realtime, e.mode, act.mode);
        errors++;
      end
      if (act.code !== e.code) begin
        $display("%0t: prescaler_code exp %0d got %0d", $realtime, e.code, act.code);
        errors++;
      end
      if (act.top !== e.top) begin
        $display("%0t: top_value exp %0d got %0d", $realtime, e.top, act.top);
        errors++;
      end
      if (act.ach !== e.ach) begin
        $display("%0t: achieved_hz exp %0d got %0d", $realtime, e.ach, act.ach);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [WANT_W-1:0] in_desired_hz;
  logic              in_timer_is_8bit;
  logic              in_timer_usable;
  logic              out_valid;
  logic              out_ready;
  logic              out_applied;
  logic [2:0]        out_wave_mode;
  logic [2:0]        out_prescaler_code;
  logic [TOP_W-1:0]  out_top_value;
  logic [ACH_W-1:0]  out_achieved_hz;
  logic              cfg_we;
  logic              cfg_index;
  logic [CLK_W-1:0]  cfg_data;

  search_scoreboard sb;
  longint unsigned  cycles;
  bit               quiet_rx;    // receiver never stalls
  bit               quiet_tx;    // sender never idles
  bit               hold_rx;     // long receiver hold-off in progress

  localparam longint unsigned CYCLE_LIMIT = 64'd4000000;

  pwm_prescaler_top_search_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run with a fail once the cycle limit is passed.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result monitor: sample at the rising edge.
  always @(posedge clk) begin
    search_res_t a;
    if (rst_n && out_valid && out_ready) begin
      a.applied = out_applied; a.mode = out_wave_mode; a.code = out_prescaler_code;
      a.top = out_top_value; a.ach = out_achieved_hz;
      sb.check_result(a);
    end
  end

  // Receiver: random stalls unless quiet, and held low during a hold-off.
  always @(negedge clk) begin
    if (!rst_n || hold_rx) out_ready <= 1'b0;
    else if (quiet_rx) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 29);
  end

  // Hold-off counted in cycles in its own process.
  task automatic rx_hold(int n);
    hold_rx = 1'b1;
    repeat (n) @(negedge clk);
    hold_rx = 1'b0;
  endtask

  // Sends one request transaction; the scoreboard notes it on acceptance.
  // Valid stays high into the next request unless the sender idles.
  task automatic send_req(logic [WANT_W-1:0] want, logic is8, logic usable);
    while (!quiet_tx && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_desired_hz <= want;
    in_timer_is_8bit <= is8;
    in_timer_usable <= usable;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(want, is8, usable);
    @(negedge clk);
  endtask

  // Waits for all results, then some slack before a config write.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CLK_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random request: mostly usable, frequencies biased toward low values.
  task automatic send_random();
    logic [WANT_W-1:0] w;
    case ($urandom_range(3))
      0: w = WANT_W'($urandom_range(0, 300));
      1: w = WANT_W'($urandom_range(0, 5000));
      default: w = WANT_W'($urandom);
    endcase
    send_req(w, 1'($urandom_range(1)), ($urandom_range(9) != 0));
  endtask

  task automatic directed();
    logic [WANT_W-1:0] wl[8];
    wl = '{16'd0, 16'd1, 16'd31, 16'd50, 16'd490, 16'd1000, 16'd20000, 16'hFFFF};
    for (int i = 0; i < 8; i++) begin
      send_req(wl[i], 1'b1, 1'b1);
      send_req(wl[i], 1'b0, 1'b1);
    end
    send_req(16'd1000, 1'b1, 1'b0);
    send_req(16'hFFFF, 1'b0, 1'b0);
    send_req(16'd0, 1'b0, 1'b0);
  endtask

  initial begin
    logic [CLK_W-1:0] clks[5];
    sb = new();
    sb.init();
    cycles = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_desired_hz = '0; in_timer_is_8bit = 1'b0;
    in_timer_usable = 1'b0; out_ready = 1'b0; cfg_we = 1'b0; cfg_index = CFG_CPU_CLOCK;
    cfg_data = '0; quiet_rx = 1'b0; quiet_tx = 1'b0; hold_rx = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings first, then extremes of both registers.
    directed();
    drain();
    clks = '{25'd1000000, 25'h1FFFFFF, 25'd16000000, 25'd8000000, 25'd20000000};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_CPU_CLOCK, (ph == 4) ? 25'($urandom_range(1000000, 33554431))
                                          : clks[ph]);
      write_reg(CFG_CMP_TOP, CLK_W'(ph[0]));
      if (ph < 2) directed();
      if (ph == 2) begin
        // Long receiver hold-off while requests keep coming.
        fork
          rx_hold(3000);
          begin
            for (int k = 0; k < 10; k++) send_random();
            in_valid <= 1'b0;
          end
        join
      end
      quiet_rx = (ph == 3);
      quiet_tx = (ph == 3);
      for (int k = 0; k < 75; k++) send_random();
      drain();
      quiet_rx = 1'b0;
      quiet_tx = 1'b0;
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pps_pkg.sv
hdl/pps_div.sv
hdl/pps_front.sv
hdl/pps_queue.sv
hdl/pps_back.sv
hdl/pwm_prescaler_top_search_unit.sv
verif/pwm_prescaler_top_search_unit_tb.sv
